>>> rtl/stmwf_pkg.sv
// Shared types, constants and step codes for the trimmed-mean weighted filter.
`default_nettype none

package stmwf_pkg;

  localparam int CHANNELS     = 4;
  localparam int WINDOW_LEN   = 8;
  localparam int HISTORY_TAPS = 3;

  localparam int CHAN_W   = 2;
  localparam int SAMPLE_W = 12;
  localparam int VAL_W    = 13;
  localparam int LIMIT_W  = 8;

  localparam logic [LIMIT_W-1:0] DEADBAND_RESET = 8'd5;

  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SORT_CNT_W = $clog2(WINDOW_LEN);

  // /3 of a three-sample sum below 2^15
  localparam int            DIV3_SHIFT = 17;
  localparam int            DIV3_W     = 16;
  localparam logic [DIV3_W-1:0] DIV3_MUL = DIV3_W'(((1 << DIV3_SHIFT) + 2) / 3);
  localparam int            SUM3_W     = VAL_W + 2;

  // trimmed mean: drop two lowest and two highest
  localparam int TRIM_CNT   = WINDOW_LEN - 4;
  localparam int MSUM_W     = VAL_W + $clog2(WINDOW_LEN);
  localparam int MEAN_SHIFT = 24;
  localparam int MEAN_MUL_W = 25;
  localparam logic [MEAN_MUL_W-1:0] MEAN_MUL =
    MEAN_MUL_W'(((1 << MEAN_SHIFT) + TRIM_CNT - 1) / TRIM_CNT);

  // recursive weighting
  localparam int TAP_W_OLD  = 2;
  localparam int TAP_W_PREV = 3;
  localparam int TAP_W_NEW  = 6;
  localparam int TAP_W_SUM  = TAP_W_OLD + TAP_W_PREV + TAP_W_NEW;
  localparam int WSUM_W     = VAL_W + 3;
  localparam int FILT_SHIFT = 20;
  localparam int FILT_MUL_W = 17;
  localparam logic [FILT_MUL_W-1:0] FILT_MUL =
    FILT_MUL_W'(((1 << FILT_SHIFT) + TAP_W_SUM - 1) / TAP_W_SUM);

  typedef struct packed {
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] first_sample;
    logic [SAMPLE_W-1:0] second_sample;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_channel;
    logic [VAL_W-1:0]  trimmed_mean;
    logic [VAL_W-1:0]  filtered_value;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_SHIFT,
    ST_SORT,
    ST_MSUM,
    ST_MDIV,
    ST_WSUM,
    ST_FDIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic sum;
    logic shift;
    logic sort_step;
    logic sort_odd;
    logic mean_sum;
    logic mean_div;
    logic wsum;
    logic fdiv;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic chan_ok;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/sensor_trimmed_mean_weighted_filter.sv
// Top level of the trimmed-mean weighted sensor filter.
// Usage:
//   Input channel in_valid/in_stall/in_data: one request carries a channel
//   index and two raw 12-bit samples. Taken when in_valid is high and
//   in_stall low. in_stall is low only while the block is idle.
//   Output channel out_valid/out_stall/out_data: one result per request with
//   the channel, the trimmed window mean and the weighted filtered value.
//   Config: cfg_wr_en/cfg_wr_data write the 8-bit dead-band limit (reset 5);
//   write only while idle.
// Sequence: an accepted request runs through sum, shift, sort, mean sum,
//   mean divide, weighted sum, filter divide and output load; the next
//   request is taken the cycle after the result is loaded. The sort is
//   odd-even transposition, one pass per cycle.
// A finished result sits in the output register; the block takes the next
//   request while it waits and only holds at the last step if the register
//   is still full when the next result is ready.
// Reset (synchronous) clears all per-channel stores, the window and output
//   history to zero and empties the output register. No clearing pass.
`default_nettype none

module sensor_trimmed_mean_weighted_filter (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire stmwf_pkg::in_item_t             in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output stmwf_pkg::out_item_t                 out_data,
  input  wire logic                            cfg_wr_en,
  input  wire logic [stmwf_pkg::LIMIT_W-1:0]   cfg_wr_data
);
  import stmwf_pkg::*;

  cmd_t    cmd;
  status_t status;

  stmwf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  stmwf_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/stmwf_datapath.sv
// Datapath: channel stores, dead-band, window sort, trimmed mean, weighting, output register.
`default_nettype none

module stmwf_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire stmwf_pkg::cmd_t                 cmd,
  output stmwf_pkg::status_t                   status,
  input  wire stmwf_pkg::in_item_t             in_data,
  input  wire logic                            cfg_wr_en,
  input  wire logic [stmwf_pkg::LIMIT_W-1:0]   cfg_wr_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output stmwf_pkg::out_item_t                 out_data
);
  import stmwf_pkg::*;

  logic [LIMIT_W-1:0]  deadband;
  logic [CHAN_W-1:0]   ch_r;
  logic [VAL_W-1:0]    s1;
  logic [VAL_W-1:0]    s2;
  logic [VAL_W-1:0]    v;
  logic [VAL_W-1:0]    last_sample    [CHANNELS];
  logic [VAL_W-1:0]    mean_window    [CHANNELS][WINDOW_LEN];
  logic [VAL_W-1:0]    hist_old       [CHANNELS];
  logic [VAL_W-1:0]    hist_prev      [CHANNELS];
  logic [VAL_W-1:0]    sorted         [WINDOW_LEN];
  logic [VAL_W-1:0]    sort_next      [WINDOW_LEN];
  logic [VAL_W-1:0]    row_next       [WINDOW_LEN];
  logic [MSUM_W-1:0]   msum;
  logic [MSUM_W-1:0]   msum_next;
  logic [VAL_W-1:0]    mean;
  logic [WSUM_W-1:0]   wsum;
  logic [VAL_W-1:0]    filt;

  logic [CH_IDX_W-1:0] ch_idx;
  logic [SUM3_W-1:0]   sum3;
  logic [SUM3_W+DIV3_W-1:0]     prod3;
  logic [MSUM_W+MEAN_MUL_W-1:0] prod_mean;
  logic [WSUM_W+FILT_MUL_W-1:0] prod_filt;
  logic [VAL_W-1:0]    prev;
  logic [VAL_W-1:0]    prev2;
  logic [VAL_W-1:0]    diff_new;
  logic [VAL_W-1:0]    diff_old;
  logic [VAL_W:0]      diff_sum;
  logic [VAL_W-1:0]    v_sel;
  logic [WSUM_W-1:0]   wsum_next;

  assign ch_idx = CH_IDX_W'(ch_r);

  assign status.chan_ok  = (int'(in_data.channel) < CHANNELS);
  assign status.out_free = !out_valid || !out_stall;

  // average of the two new samples and the stored one
  assign sum3  = SUM3_W'(s1) + SUM3_W'(s2) + SUM3_W'(last_sample[ch_idx]);
  assign prod3 = (SUM3_W+DIV3_W)'(sum3) * (SUM3_W+DIV3_W)'(DIV3_MUL);

  // dead-band on the newest two window entries
  assign prev     = mean_window[ch_idx][WINDOW_LEN-1];
  assign prev2    = mean_window[ch_idx][WINDOW_LEN-2];
  assign diff_new = (v > prev) ? (v - prev) : (prev - v);
  assign diff_old = (prev > prev2) ? (prev - prev2) : (prev2 - prev);
  assign diff_sum = (VAL_W+1)'(diff_new) + (VAL_W+1)'(diff_old);
  assign v_sel    = (diff_sum < (VAL_W+1)'(deadband)) ? prev : v;

  always_comb begin
    for (int i = 0; i < WINDOW_LEN - 1; i++) begin
      row_next[i] = mean_window[ch_idx][i+1];
    end
    row_next[WINDOW_LEN-1] = v_sel;
  end

  // one odd-even transposition pass; disjoint pairs
  always_comb begin
    sort_next = sorted;
    for (int i = 0; i < WINDOW_LEN - 1; i++) begin
      if (((i % 2) == int'(cmd.sort_odd)) && (sorted[i] > sorted[i+1])) begin
        sort_next[i]   = sorted[i+1];
        sort_next[i+1] = sorted[i];
      end
    end
  end

  always_comb begin
    msum_next = '0;
    for (int i = 2; i < WINDOW_LEN - 2; i++) begin
      msum_next = msum_next + MSUM_W'(sorted[i]);
    end
  end

  assign prod_mean = (MSUM_W+MEAN_MUL_W)'(msum) * (MSUM_W+MEAN_MUL_W)'(MEAN_MUL);

  assign wsum_next = WSUM_W'(hist_old[ch_idx])  * WSUM_W'(TAP_W_OLD)
                   + WSUM_W'(hist_prev[ch_idx]) * WSUM_W'(TAP_W_PREV)
                   + WSUM_W'(mean)              * WSUM_W'(TAP_W_NEW);

  assign prod_filt = (WSUM_W+FILT_MUL_W)'(wsum) * (WSUM_W+FILT_MUL_W)'(FILT_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband <= DEADBAND_RESET;
    end else if (cfg_wr_en) begin
      deadband <= cfg_wr_data;
    end
  end

  // per-channel stores
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        last_sample[c] <= '0;
        hist_old[c]    <= '0;
        hist_prev[c]   <= '0;
        for (int k = 0; k < WINDOW_LEN; k++) begin
          mean_window[c][k] <= '0;
        end
      end
    end else begin
      if (cmd.sum) begin
        last_sample[ch_idx] <= s2;
      end
      if (cmd.shift) begin
        mean_window[ch_idx] <= row_next;
      end
      if (cmd.fdiv) begin
        hist_old[ch_idx]  <= hist_prev[ch_idx];
        hist_prev[ch_idx] <= VAL_W'(prod_filt >> FILT_SHIFT);
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ch_r <= in_data.channel;
      s1   <= VAL_W'(in_data.first_sample) + VAL_W'(1);
      s2   <= VAL_W'(in_data.second_sample) + VAL_W'(1);
    end
    if (cmd.sum) begin
      v <= VAL_W'(prod3 >> DIV3_SHIFT);
    end
    if (cmd.shift) begin
      sorted <= row_next;
    end else if (cmd.sort_step) begin
      sorted <= sort_next;
    end
    if (cmd.mean_sum) begin
      msum <= msum_next;
    end
    if (cmd.mean_div) begin
      mean <= VAL_W'(prod_mean >> MEAN_SHIFT);
    end
    if (cmd.wsum) begin
      wsum <= wsum_next;
    end
    if (cmd.fdiv) begin
      filt <= VAL_W'(prod_filt >> FILT_SHIFT);
    end
  end

  // output register: holds a finished request while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.out_channel    <= ch_r;
      out_data.trimmed_mean   <= mean;
      out_data.filtered_value <= filt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/stmwf_ctrl.sv
// Controller: sequences one request through the datapath steps.
`default_nettype none

module stmwf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output stmwf_pkg::cmd_t         cmd,
  input  wire stmwf_pkg::status_t status
);
  import stmwf_pkg::*;

  localparam logic [SORT_CNT_W-1:0] SORT_LAST = SORT_CNT_W'(WINDOW_LEN - 1);

  state_t                state;
  state_t                state_next;
  logic [SORT_CNT_W-1:0] sort_cnt;
  logic [SORT_CNT_W-1:0] sort_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      sort_cnt <= '0;
    end else begin
      state    <= state_next;
      sort_cnt <= sort_cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    sort_cnt_next = sort_cnt;
    cmd           = '0;
    in_stall      = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          // unknown channel: request dropped, only the input registers are loaded
          if (status.chan_ok) begin
            state_next = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd.shift     = 1'b1;
        sort_cnt_next = '0;
        state_next    = ST_SORT;
      end
      ST_SORT: begin
        cmd.sort_step = 1'b1;
        cmd.sort_odd  = sort_cnt[0];
        sort_cnt_next = sort_cnt + SORT_CNT_W'(1);
        if (sort_cnt == SORT_LAST) begin
          state_next = ST_MSUM;
        end
      end
      ST_MSUM: begin
        cmd.mean_sum = 1'b1;
        state_next   = ST_MDIV;
      end
      ST_MDIV: begin
        cmd.mean_div = 1'b1;
        state_next   = ST_WSUM;
      end
      ST_WSUM: begin
        cmd.wsum   = 1'b1;
        state_next = ST_FDIV;
      end
      ST_FDIV: begin
        cmd.fdiv   = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_in, cmd.sum, cmd.shift, cmd.sort_step, cmd.mean_sum,
              cmd.mean_div, cmd.wsum, cmd.fdiv, cmd.out_load}))
    else $error("more than one datapath step in a cycle");

  a_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_in && status.chan_ok) |=> (state == ST_SUM))
    else $error("accepted request did not start processing");

  a_sort_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MSUM) |-> ($past(state) == ST_SORT && $past(sort_cnt) == SORT_LAST))
    else $error("sort left before all passes");

  a_out_room: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("output register overwritten while held");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !cmd.load_in)
    else $error("input loaded while busy");

endmodule

`default_nettype wire

>>> bench/tb_sensor_trimmed_mean_weighted_filter.sv
// Self-checking bench for the trimmed-mean weighted sensor filter.
`timescale 1ns / 1ps

module tb_sensor_trimmed_mean_weighted_filter;
  import stmwf_pkg::*;

  class trim_filter_scoreboard;
    int unsigned deadband;
    int unsigned prev_later[CHANNELS];
    int unsigned window[CHANNELS][WINDOW_LEN];
    int unsigned past_out[CHANNELS][2];
    out_item_t   expected_results[$];
    int          fail_count;

    function new();
      deadband   = DEADBAND_RESET;
      fail_count = 0;
      foreach (prev_later[c]) prev_later[c] = 0;
      foreach (window[c, i]) window[c][i] = 0;
      foreach (past_out[c, i]) past_out[c][i] = 0;
    endfunction

    function int unsigned gap(int unsigned a, int unsigned b);
      return (a > b) ? a - b : b - a;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // works out the result of one accepted request and queues it
    function void take_request(in_item_t req);
      int unsigned ch, s1, s2, v, prv, prv2, acc, mean, filt, tmp;
      int unsigned srt[WINDOW_LEN];
      out_item_t   res;
      ch = req.channel;
      if (ch >= CHANNELS) return;
      // +1 never leaves 1..4096, which fits the 13-bit value width
      s1 = req.first_sample + 1;
      s2 = req.second_sample + 1;
      v  = (s1 + s2 + prev_later[ch]) / 3;
      prev_later[ch] = s2;
      prv  = window[ch][WINDOW_LEN-1];
      prv2 = window[ch][WINDOW_LEN-2];
      if (gap(v, prv) + gap(prv, prv2) < deadband) v = prv;
      for (int i = 0; i < WINDOW_LEN - 1; i++) window[ch][i] = window[ch][i+1];
      window[ch][WINDOW_LEN-1] = v;
      for (int i = 0; i < WINDOW_LEN; i++) srt[i] = window[ch][i];
      for (int i = 0; i < WINDOW_LEN - 1; i++)
        for (int j = 0; j < WINDOW_LEN - 1 - i; j++)
          if (srt[j] > srt[j+1]) begin
            tmp      = srt[j];
            srt[j]   = srt[j+1];
            srt[j+1] = tmp;
          end
      acc = 0;
      for (int i = 2; i < WINDOW_LEN - 2; i++) acc += srt[i];
      mean = acc / (WINDOW_LEN - 4);
      filt = (2 * past_out[ch][0] + 3 * past_out[ch][1] + 6 * mean) / 11;
      past_out[ch][0] = past_out[ch][1];
      past_out[ch][1] = filt;
      res.out_channel    = CHAN_W'(ch);
      res.trimmed_mean   = VAL_W'(mean);
      res.filtered_value = VAL_W'(filt);
      expected_results.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        $error("result with nothing pending: chan %0d mean %0d filt %0d",
               got.out_channel, got.trimmed_mean, got.filtered_value);
        fail_count++;
        return;
      end
      want = expected_results.pop_front();
      if (got.out_channel !== want.out_channel) begin
        $error("out_channel: expected %0d, got %0d", want.out_channel, got.out_channel);
        fail_count++;
      end
      if (got.trimmed_mean !== want.trimmed_mean) begin
        $error("trimmed_mean: expected %0d, got %0d", want.trimmed_mean, got.trimmed_mean);
        fail_count++;
      end
      if (got.filtered_value !== want.filtered_value) begin
        $error("filtered_value: expected %0d, got %0d",
               want.filtered_value, got.filtered_value);
        fail_count++;
      end
    endfunction
  endclass

  localparam int HOLD_CYCLES = 400;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_wr_en;
  logic [LIMIT_W-1:0]   cfg_wr_data;

  trim_filter_scoreboard sb;
  int  idle_pct;
  int  stall_pct;
  bit  hold_req;
  int  level[CHANNELS];

  sensor_trimmed_mean_weighted_filter DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.take_request(in_data);
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // output side: random stalls, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int bound(int x);
    return (x < 0) ? 0 : (x > 4095) ? 4095 : x;
  endfunction

  // mostly slow drifting signals so the dead-band gets exercised
  function automatic in_item_t random_request();
    in_item_t    req;
    int unsigned ch, pick;
    int          a, b;
    ch   = $urandom_range(0, CHANNELS - 1);
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 39) == 0) level[ch] = $urandom_range(0, 4095);
    if (pick < 55) begin
      level[ch] = bound(level[ch] + int'($urandom_range(0, 6)) - 3);
      a = bound(level[ch] + int'($urandom_range(0, 4)) - 2);
      b = bound(level[ch] + int'($urandom_range(0, 4)) - 2);
    end else if (pick < 65) begin
      a = level[ch];
      b = level[ch];
    end else if (pick < 88) begin
      a = $urandom_range(0, 4095);
      b = $urandom_range(0, 4095);
    end else begin
      a = $urandom_range(0, 1) ? 4095 : 0;
      b = $urandom_range(0, 1) ? 4095 : 0;
    end
    req.channel       = CHAN_W'(ch);
    req.first_sample  = SAMPLE_W'(a);
    req.second_sample = SAMPLE_W'(b);
    return req;
  endfunction

  // entered and left at a falling edge; valid is left high on return
  task automatic send_request(input in_item_t req);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send(input int ch, input int a, input int b);
    in_item_t req;
    req.channel       = CHAN_W'(ch);
    req.first_sample  = SAMPLE_W'(a);
    req.second_sample = SAMPLE_W'(b);
    send_request(req);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_limit(input int unsigned v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= LIMIT_W'(v);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.deadband = v;
  endtask

  task automatic run_phase(input int n, input int idle, input int stall, input bit long_hold);
    idle_pct  = idle;
    stall_pct = stall;
    if (long_hold) hold_req = 1'b1;
    repeat (n) send_request(random_request());
    drain();
  endtask

  initial begin
    sb          = new();
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_req    = 1'b0;
    foreach (level[c]) level[c] = 2048;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset limit; zeros from reset feed the first windows
    send(0, 0, 0);
    send(0, 0, 0);
    send(0, 4095, 4095);
    send(0, 4095, 0);
    send(0, 0, 4095);
    for (int c = 1; c < CHANNELS; c++) begin
      send(c, 4095, 4095);
      send(c, 0, 0);
    end
    // settle on a flat level so the dead-band holds, then nudge it
    repeat (5) send(2, 2047, 2047);
    send(2, 2049, 2048);
    send(2, 2046, 2047);
    send(3, 100, 100);
    send(3, 101, 101);
    send(3, 102, 102);
    drain();

    // limit 0 never holds; long output hold-off backs up the input
    write_limit(0);
    run_phase(170, 0, 0, 1'b1);
    write_limit(255);
    run_phase(170, 50, 0, 1'b0);
    write_limit($urandom_range(1, 254));
    run_phase(170, 0, 50, 1'b0);
    write_limit($urandom_range(0, 255));
    run_phase(170, 13, 13, 1'b0);
    write_limit(DEADBAND_RESET);
    run_phase(170, 0, 0, 1'b0);

    if (sb.fail_count == 0 && sb.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

>>> files.f
rtl/stmwf_pkg.sv
rtl/stmwf_datapath.sv
rtl/stmwf_ctrl.sv
rtl/sensor_trimmed_mean_weighted_filter.sv
bench/tb_sensor_trimmed_mean_weighted_filter.sv
